// ----- rtl/fds_pkg.sv -----
// Shared types, widths, codes and helper functions for the facing direction select block.
// No dependencies; every other file imports this package.
package fds_pkg;

    localparam int FRAC_BITS = 14;
    localparam int VW        = 16;
    localparam int PW        = 2 * VW;
    localparam int CW        = PW + 1;
    localparam int MW        = PW;
    localparam int SW        = 2 * MW;
    localparam int LW        = SW / 2;
    localparam int NW        = MW + FRAC_BITS + 1;
    localparam int QW        = FRAC_BITS + 1;
    localparam int CFG_IW    = 3;

    typedef logic signed [VW-1:0] t_comp;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [CW-1:0] t_cross;
    typedef logic [MW-1:0]        t_mag;
    typedef logic [SW-1:0]        t_sq;
    typedef logic [LW-1:0]        t_root;
    typedef logic [NW-1:0]        t_num;
    typedef logic [QW-1:0]        t_quot;
    typedef logic [3:0]           t_mode;
    typedef logic [1:0]           t_level;

    localparam t_mode MODE_BASE     = 4'd0;
    localparam t_mode MODE_REV      = 4'd1;
    localparam t_mode MODE_PERP     = 4'd2;
    localparam t_mode MODE_REV_PERP = 4'd3;

    localparam t_level LVL_WORLD_UP  = 2'd0;
    localparam t_level LVL_UNIT_UP   = 2'd1;
    localparam t_level LVL_WORLD_FWD = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_WUP_X  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_WUP_Y  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_WUP_Z  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_WFWD_X = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_WFWD_Y = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_WFWD_Z = 3'd5;

    localparam t_comp COMP_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam t_comp COMP_MAX = {1'b0, {(VW-1){1'b1}}};

    typedef struct packed {
        logic        written;
        logic        negate;
        logic        norm;
        t_level      level;
        t_comp [2:0] dir;
        logic [2:0]  neg_c;
    } t_ctl;

    function automatic t_comp neg_sat(input t_comp v);
        t_comp r;
        if (v == COMP_MIN) begin
            r = COMP_MAX;
        end else begin
            r = -v;
        end
        return r;
    endfunction

    function automatic t_comp sat_quot(input t_quot q, input logic neg);
        logic [31:0] qe;
        t_comp       r;
        qe = 32'(q);
        if (neg) begin
            if (qe > 32'd32768) begin
                r = COMP_MIN;
            end else begin
                r = -qe[VW-1:0];
            end
        end else begin
            if (qe > 32'd32767) begin
                r = COMP_MAX;
            end else begin
                r = qe[VW-1:0];
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/fds_cross.sv -----
// Cross product front end: products, difference and fallback selection, magnitudes, squares.
// Four register stages; depends on fds_pkg.
module fds_cross
    import fds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  t_mode       i_mode,
    input  t_comp [2:0] i_base,
    input  t_comp [2:0] i_up,
    input  t_comp [2:0] i_wup,
    input  t_comp [2:0] i_wfwd,
    output logic        o_vld,
    output t_ctl        o_ctl,
    output t_mag [2:0]  o_mag,
    output t_sq [2:0]   o_sq
);

    logic        r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    t_mode       r_a_mode;
    t_comp [2:0] r_a_base;
    t_prod [5:0] r_pw, r_pu;

    t_ctl         r_b_ctl;
    t_cross [2:0] r_b_c;

    t_ctl        r_c_ctl;
    t_mag [2:0]  r_c_mag;

    t_ctl        r_d_ctl;
    t_mag [2:0]  r_d_mag;
    t_sq [2:0]   r_d_sq;

    t_cross [2:0] w_cw, w_cu, w_sel;
    logic         w_perp;
    t_ctl         w_b_ctl, w_c_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mode <= i_mode;
        r_a_base <= i_base;
        r_pw[0]  <= i_wup[1] * i_base[2];
        r_pw[1]  <= i_wup[2] * i_base[1];
        r_pw[2]  <= i_wup[2] * i_base[0];
        r_pw[3]  <= i_wup[0] * i_base[2];
        r_pw[4]  <= i_wup[0] * i_base[1];
        r_pw[5]  <= i_wup[1] * i_base[0];
        r_pu[0]  <= i_up[1] * i_base[2];
        r_pu[1]  <= i_up[2] * i_base[1];
        r_pu[2]  <= i_up[2] * i_base[0];
        r_pu[3]  <= i_up[0] * i_base[2];
        r_pu[4]  <= i_up[0] * i_base[1];
        r_pu[5]  <= i_up[1] * i_base[0];
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_cw[j] = t_cross'(r_pw[2*j]) - t_cross'(r_pw[2*j+1]);
            w_cu[j] = t_cross'(r_pu[2*j]) - t_cross'(r_pu[2*j+1]);
        end
        w_b_ctl         = '0;
        w_sel           = w_cw;
        w_b_ctl.written = (r_a_mode <= MODE_REV_PERP);
        w_b_ctl.negate  = (r_a_mode == MODE_REV) || (r_a_mode == MODE_REV_PERP);
        w_perp          = (r_a_mode == MODE_PERP) || (r_a_mode == MODE_REV_PERP);
        priority if (!w_b_ctl.written) begin
            w_b_ctl.level = LVL_WORLD_UP;
        end else if (!w_perp) begin
            w_b_ctl.dir = r_a_base;
        end else if (w_cw != '0) begin
            w_b_ctl.norm  = 1'b1;
            w_b_ctl.level = LVL_WORLD_UP;
        end else if (w_cu != '0) begin
            w_b_ctl.norm  = 1'b1;
            w_b_ctl.level = LVL_UNIT_UP;
            w_sel         = w_cu;
        end else begin
            w_b_ctl.level = LVL_WORLD_FWD;
            w_b_ctl.dir   = i_wfwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_ctl <= w_b_ctl;
        r_b_c   <= w_sel;
    end

    always_comb begin
        w_c_ctl = r_b_ctl;
        for (int j = 0; j < 3; j++) begin
            w_c_ctl.neg_c[j] = r_b_c[j][CW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_ctl <= w_c_ctl;
        for (int j = 0; j < 3; j++) begin
            r_c_mag[j] <= r_b_c[j][CW-1] ? MW'(-r_b_c[j]) : MW'(r_b_c[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_ctl <= r_c_ctl;
        r_d_mag <= r_c_mag;
        for (int j = 0; j < 3; j++) begin
            r_d_sq[j] <= r_c_mag[j] * r_c_mag[j];
        end
    end

    assign o_vld = r_d_vld;
    assign o_ctl = r_d_ctl;
    assign o_mag = r_d_mag;
    assign o_sq  = r_d_sq;

endmodule

// ----- rtl/fds_sqrt.sv -----
// Sum of squares and a fully pipelined integer square root, one result bit per stage.
// Depends on fds_pkg.
module fds_sqrt
    import fds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  t_ctl       i_ctl,
    input  t_mag [2:0] i_mag,
    input  t_sq [2:0]  i_sq,
    output logic       o_vld,
    output t_ctl       o_ctl,
    output t_mag [2:0] o_mag,
    output t_root      o_root
);

    logic [LW:0] r_vld;
    t_sq         r_rem  [0:LW];
    t_root       r_root [0:LW];
    t_ctl        r_ctl  [0:LW];
    t_mag [2:0]  r_mag  [0:LW];
    t_sq         w_trial [1:LW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LW-1:0], i_vld};
        end
    end

    always_comb begin
        for (int k = 1; k <= LW; k++) begin
            w_trial[k] = (SW'(r_root[k-1]) << (LW - k + 1)) | (SW'(1) << (2 * (LW - k)));
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_sq[0] + i_sq[1] + i_sq[2];
        r_root[0] <= '0;
        r_ctl[0]  <= i_ctl;
        r_mag[0]  <= i_mag;
        for (int k = 1; k <= LW; k++) begin
            if (r_rem[k-1] >= w_trial[k]) begin
                r_rem[k]  <= r_rem[k-1] - w_trial[k];
                r_root[k] <= r_root[k-1] | (LW'(1) << (LW - k));
            end else begin
                r_rem[k]  <= r_rem[k-1];
                r_root[k] <= r_root[k-1];
            end
            r_ctl[k] <= r_ctl[k-1];
            r_mag[k] <= r_mag[k-1];
        end
    end

    assign o_vld  = r_vld[LW];
    assign o_ctl  = r_ctl[LW];
    assign o_mag  = r_mag[LW];
    assign o_root = r_root[LW];

    // A nonzero cross product never yields a zero length.
    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LW] && r_ctl[LW].norm |-> r_root[LW] != '0)
        else $error("zero length for a nonzero cross product");

    // The final remainder of a floor square root never exceeds twice the root.
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LW] |-> r_rem[LW] <= (SW'(r_root[LW]) << 1))
        else $error("square root remainder out of range");

endmodule

// ----- rtl/fds_div.sv -----
// Rounded division of each magnitude by the length, one quotient bit per stage, then the
// sign, saturation and negation output stage. Depends on fds_pkg.
module fds_div
    import fds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  t_ctl       i_ctl,
    input  t_mag [2:0] i_mag,
    input  t_root      i_root,
    output logic       o_vld,
    output t_comp      o_dir_x,
    output t_comp      o_dir_y,
    output t_comp      o_dir_z,
    output logic       o_dir_written,
    output t_level     o_fallback_level
);

    logic [QW:0] r_vld;
    t_num [2:0]  r_rem [0:QW];
    t_quot [2:0] r_q   [0:QW];
    t_root       r_den [0:QW];
    t_ctl        r_ctl [0:QW];
    t_num        w_sub [1:QW];

    logic        r_out_vld;
    t_comp [2:0] r_out_dir;
    logic        r_out_written;
    t_level      r_out_level;
    t_comp [2:0] w_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[QW-1:0], i_vld};
            r_out_vld <= r_vld[QW];
        end
    end

    always_comb begin
        for (int k = 1; k <= QW; k++) begin
            w_sub[k] = NW'(r_den[k-1]) << (QW - k);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_rem[0][j] <= (NW'(i_mag[j]) << FRAC_BITS) + NW'(i_root >> 1);
        end
        r_q[0]   <= '0;
        r_den[0] <= i_root;
        r_ctl[0] <= i_ctl;
        for (int k = 1; k <= QW; k++) begin
            for (int j = 0; j < 3; j++) begin
                if (r_rem[k-1][j] >= w_sub[k]) begin
                    r_rem[k][j] <= r_rem[k-1][j] - w_sub[k];
                    r_q[k][j]   <= r_q[k-1][j] | (QW'(1) << (QW - k));
                end else begin
                    r_rem[k][j] <= r_rem[k-1][j];
                    r_q[k][j]   <= r_q[k-1][j];
                end
            end
            r_den[k] <= r_den[k-1];
            r_ctl[k] <= r_ctl[k-1];
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_dir[j] = r_ctl[QW].norm ? sat_quot(r_q[QW][j], r_ctl[QW].neg_c[j])
                                      : r_ctl[QW].dir[j];
            if (r_ctl[QW].negate) begin
                w_dir[j] = neg_sat(w_dir[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_dir     <= w_dir;
        r_out_written <= r_ctl[QW].written;
        r_out_level   <= r_ctl[QW].level;
    end

    assign o_vld            = r_out_vld;
    assign o_dir_x          = r_out_dir[0];
    assign o_dir_y          = r_out_dir[1];
    assign o_dir_z          = r_out_dir[2];
    assign o_dir_written    = r_out_written;
    assign o_fallback_level = r_out_level;

    // Each component is at most the length, so no quotient exceeds one in fixed point.
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QW] && r_ctl[QW].norm |->
            r_q[QW][0] <= QW'(2 ** FRAC_BITS) && r_q[QW][1] <= QW'(2 ** FRAC_BITS)
            && r_q[QW][2] <= QW'(2 ** FRAC_BITS))
        else $error("normalized component above one");

    // Long division must leave a remainder below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QW] && r_ctl[QW].norm |->
            r_rem[QW][0] < NW'(r_den[QW]) && r_rem[QW][1] < NW'(r_den[QW])
            && r_rem[QW][2] < NW'(r_den[QW]))
        else $error("division remainder not below the length");

endmodule

// ----- rtl/facing_direction_select_core.sv -----
// Top level of the facing direction select block: configuration registers, input stage and
// the cross, square root and division pipelines. Depends on fds_pkg, fds_cross, fds_sqrt, fds_div.
//
//   Channel   Handshake                 Payload
//   ------    ----------------------    --------------------------------------------------
//   command   i_start, o_busy           i_facing_mode, i_use_own_facing, own/unit facing,
//                                       unit up (signed Q1.14)
//   result    o_valid (strobe)          o_dir_x/y/z, o_dir_written, o_fallback_level
//   config    i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A transaction is accepted in every cycle in which i_start is high; o_busy stays low.
// Each result appears on o_valid in order, after the input register, the cross front end, the
// 33-stage square root with its sum of squares, the 16-stage divider and its output stage.
// Reset is synchronous and active low; it clears all valid bits and reloads the configuration.
// The receiver cannot stall, so no stage ever holds.
module facing_direction_select_core
    import fds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  t_mode             i_facing_mode,
    input  logic              i_use_own_facing,
    input  t_comp             i_own_facing_x,
    input  t_comp             i_own_facing_y,
    input  t_comp             i_own_facing_z,
    input  t_comp             i_unit_facing_x,
    input  t_comp             i_unit_facing_y,
    input  t_comp             i_unit_facing_z,
    input  t_comp             i_unit_up_x,
    input  t_comp             i_unit_up_y,
    input  t_comp             i_unit_up_z,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  t_comp             i_cfg_data,
    output logic              o_valid,
    output t_comp             o_dir_x,
    output t_comp             o_dir_y,
    output t_comp             o_dir_z,
    output logic              o_dir_written,
    output t_level            o_fallback_level
);

    localparam t_comp WUP_RST_X  = 16'sd0;
    localparam t_comp WUP_RST_Y  = 16'sd0;
    localparam t_comp WUP_RST_Z  = 16'sd16384;
    localparam t_comp WFWD_RST_X = 16'sd16384;
    localparam t_comp WFWD_RST_Y = 16'sd0;
    localparam t_comp WFWD_RST_Z = 16'sd0;

    t_comp [2:0] r_wup, r_wfwd;
    logic        r_s0_vld;
    t_mode       r_s0_mode;
    t_comp [2:0] r_s0_base, r_s0_up;
    logic        w_accept;

    logic        w_x_vld, w_q_vld;
    t_ctl        w_x_ctl, w_q_ctl;
    t_mag [2:0]  w_x_mag, w_q_mag;
    t_sq [2:0]   w_x_sq;
    t_root       w_q_root;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wup  <= {WUP_RST_Z, WUP_RST_Y, WUP_RST_X};
            r_wfwd <= {WFWD_RST_Z, WFWD_RST_Y, WFWD_RST_X};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WUP_X:  r_wup[0]  <= i_cfg_data;
                CFG_WUP_Y:  r_wup[1]  <= i_cfg_data;
                CFG_WUP_Z:  r_wup[2]  <= i_cfg_data;
                CFG_WFWD_X: r_wfwd[0] <= i_cfg_data;
                CFG_WFWD_Y: r_wfwd[1] <= i_cfg_data;
                CFG_WFWD_Z: r_wfwd[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_mode <= i_facing_mode;
        r_s0_up   <= {i_unit_up_z, i_unit_up_y, i_unit_up_x};
        if (i_use_own_facing) begin
            r_s0_base <= {i_own_facing_z, i_own_facing_y, i_own_facing_x};
        end else begin
            r_s0_base <= {i_unit_facing_z, i_unit_facing_y, i_unit_facing_x};
        end
    end

    fds_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s0_vld),
        .i_mode  (r_s0_mode),
        .i_base  (r_s0_base),
        .i_up    (r_s0_up),
        .i_wup   (r_wup),
        .i_wfwd  (r_wfwd),
        .o_vld   (w_x_vld),
        .o_ctl   (w_x_ctl),
        .o_mag   (w_x_mag),
        .o_sq    (w_x_sq)
    );

    fds_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_x_vld),
        .i_ctl   (w_x_ctl),
        .i_mag   (w_x_mag),
        .i_sq    (w_x_sq),
        .o_vld   (w_q_vld),
        .o_ctl   (w_q_ctl),
        .o_mag   (w_q_mag),
        .o_root  (w_q_root)
    );

    fds_div u_div (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_vld            (w_q_vld),
        .i_ctl            (w_q_ctl),
        .i_mag            (w_q_mag),
        .i_root           (w_q_root),
        .o_vld            (o_valid),
        .o_dir_x          (o_dir_x),
        .o_dir_y          (o_dir_y),
        .o_dir_z          (o_dir_z),
        .o_dir_written    (o_dir_written),
        .o_fallback_level (o_fallback_level)
    );

    // A transaction with no direction update carries an all-zero result.
    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_dir_written |->
            o_dir_x == '0 && o_dir_y == '0 && o_dir_z == '0
            && o_fallback_level == LVL_WORLD_UP)
        else $error("unwritten result carries a nonzero field");

endmodule
